/* src/fdmd_pkg.sv */
`timescale 1ns / 1ps

package fdmd_pkg;

  // Store depth and derived widths
  localparam int MAX_FRAME_BYTES = 131072;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES);

  // Field widths
  localparam int PIX_W  = 8;
  localparam int LEN_W  = 18;
  localparam int SENS_W = 12;
  localparam int SUM_W  = 25;
  localparam int PROD_W = SENS_W + LEN_W;
  localparam int DIFF_W = PIX_W;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Configuration port
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_BYTES = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_SENSITIVITY = 1'd1;

  localparam logic [LEN_W-1:0]  FRAME_BYTES_RST = 18'd76800;
  localparam logic [SENS_W-1:0] SENSITIVITY_RST = 12'd160;

  // Word handed from the front stage to the accumulate stage
  typedef struct packed {
    logic              cmp;   // compare against stored byte
    logic              res;   // last byte of a compared frame
    logic              last;  // last byte of any frame
    logic [PIX_W-1:0]  px;
    logic [PROD_W-1:0] rhs;   // sensitivity_q4 * effective length
  } s1_word_t;

endpackage

/* src/fdmd_ram.sv */
`timescale 1ns / 1ps

module fdmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and write of the same entry returns the old data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/fdmd_front.sv */
`timescale 1ns / 1ps

module fdmd_front
  import fdmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              stall,
  input  logic [PIX_W-1:0]  pixel_byte,
  input  logic [LEN_W-1:0]  frame_bytes,
  input  logic [SENS_W-1:0] sensitivity_q4,
  output logic              ram_we,
  output logic              ram_re,
  output logic [POS_W-1:0]  ram_addr,
  output logic [PIX_W-1:0]  ram_wdata,
  output logic              s1_valid,
  output s1_word_t          s1_word
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             skip_r, skip_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic             s1_valid_r;
  s1_word_t         s1_word_r;

  logic [LEN_W-1:0] len_eff;
  logic [POS_W-1:0] pos_cur;
  logic             last;
  logic             proc;

  always_comb begin
    if (frame_bytes == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(frame_bytes) > MAX_FRAME_BYTES) begin
      len_eff = LEN_W'(MAX_FRAME_BYTES);
    end else begin
      len_eff = frame_bytes;
    end
  end

  // Clamp the position when the length shrank mid-frame
  always_comb begin
    if (32'(pos_r) >= 32'(len_eff)) begin
      pos_cur = POS_W'(len_eff - LEN_W'(1));
    end else begin
      pos_cur = pos_r;
    end
    last = (32'(pos_cur) + 32'd1) >= 32'(len_eff);
    proc = !skip_r;
  end

  assign ram_we    = accept && proc;
  assign ram_re    = accept && proc && have_prev_r;
  assign ram_addr  = pos_cur;
  assign ram_wdata = pixel_byte;

  always_comb begin
    pos_nxt       = pos_r;
    skip_nxt      = skip_r;
    have_prev_nxt = have_prev_r;
    if (accept) begin
      if (last) begin
        pos_nxt  = '0;
        skip_nxt = !skip_r;
        if (proc) begin
          have_prev_nxt = 1'b1;
        end
      end else begin
        pos_nxt = pos_cur + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      skip_r      <= 1'b0;
      have_prev_r <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      skip_r      <= skip_nxt;
      have_prev_r <= have_prev_nxt;
      if (!stall) begin
        s1_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r.cmp  <= proc && have_prev_r;
      s1_word_r.res  <= proc && have_prev_r && last;
      s1_word_r.last <= last;
      s1_word_r.px   <= pixel_byte;
      s1_word_r.rhs  <= PROD_W'(sensitivity_q4) * PROD_W'(len_eff);
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_word  = s1_word_r;

endmodule

/* src/fdmd_accum.sv */
`timescale 1ns / 1ps

module fdmd_accum
  import fdmd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s1_valid,
  input  s1_word_t         s1_word,
  input  logic [PIX_W-1:0] old_byte,
  output logic             stall,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_motion_detected,
  output logic [SUM_W-1:0] out_difference_sum
);

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              s2_res_r;
  logic [SUM_W-1:0]  s2_sum_r;
  logic [PROD_W-1:0] s2_rhs_r;
  logic              out_valid_r, out_valid_nxt;
  logic              motion_r;
  logic [SUM_W-1:0]  out_sum_r;

  logic [DIFF_W-1:0] diff;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_sat;

  // Hold everything only when a finished result cannot move on
  assign stall = s2_res_r && out_valid_r && !out_ready;

  always_comb begin
    diff     = (s1_word.px >= old_byte) ? (s1_word.px - old_byte) : (old_byte - s1_word.px);
    sum_wide = {1'b0, sum_r} + (SUM_W + 1)'(diff);
    sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    sum_nxt  = sum_r;
    if (s1_valid) begin
      if (s1_word.last) begin
        sum_nxt = '0;
      end else if (s1_word.cmp) begin
        sum_nxt = sum_sat;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (!stall && s2_res_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      s2_res_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (!stall) begin
        sum_r    <= sum_nxt;
        s2_res_r <= s1_valid && s1_word.res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s2_sum_r <= sum_sat;
      s2_rhs_r <= s1_word.rhs;
      if (s2_res_r) begin
        motion_r  <= PROD_W'({s2_sum_r, 4'b0000}) > s2_rhs_r;
        out_sum_r <= s2_sum_r;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_motion_detected = motion_r;
  assign out_difference_sum  = out_sum_r;

endmodule

/* src/frame_difference_motion_detector.sv */
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// input     in_valid / in_ready        in_pixel_byte[7:0]
// result    out_valid / out_ready      out_motion_detected, out_difference_sum[24:0]
// config    psel penable pwrite pready paddr[2:0] pwdata[31:0] prdata[31:0]
//
// One byte is taken every cycle while in_ready is high; a result passes the front, second
// and output registers after the byte that closes a compared frame. The rate is set by the
// single read-first port pair of the frame store: each byte of a non-skipped frame reads
// (once a frame is stored) and rewrites its own entry in the cycle it is accepted.
// Synchronous active-low reset clears position, frame parity and the running sum; the
// frame store is not cleared. in_ready drops only while a result sits in the second
// stage and the output register still holds an untaken word.

module frame_difference_motion_detector
  import fdmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_pixel_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_motion_detected,
  output logic [SUM_W-1:0]  out_difference_sum,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [LEN_W-1:0]     frame_bytes_r;
  logic [SENS_W-1:0]    sensitivity_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  logic                 stall;
  logic                 accept;
  logic                 ram_we;
  logic                 ram_re;
  logic [POS_W-1:0]     ram_addr;
  logic [PIX_W-1:0]     ram_wdata;
  logic [PIX_W-1:0]     ram_rdata;
  logic                 s1_valid;
  s1_word_t             s1_word;

  // Register file: one 32-bit word per register, index from the word address
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bytes_r <= FRAME_BYTES_RST;
      sensitivity_r <= SENSITIVITY_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_BYTES: frame_bytes_r <= pwdata[LEN_W-1:0];
        REG_SENSITIVITY: sensitivity_r <= pwdata[SENS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_BYTES: prdata = DATA_W'(frame_bytes_r);
      REG_SENSITIVITY: prdata = DATA_W'(sensitivity_r);
      default:         prdata = '0;
    endcase
  end

  // Take a byte whenever the back end is not holding
  assign in_ready = !stall;
  assign accept   = in_valid && in_ready;

  // Position tracking, frame parity and store addressing
  fdmd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .stall          (stall),
    .pixel_byte     (in_pixel_byte),
    .frame_bytes    (frame_bytes_r),
    .sensitivity_q4 (sensitivity_r),
    .ram_we         (ram_we),
    .ram_re         (ram_re),
    .ram_addr       (ram_addr),
    .ram_wdata      (ram_wdata),
    .s1_valid       (s1_valid),
    .s1_word        (s1_word)
  );

  // Frame store: old byte comes out while the new one goes in
  fdmd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_FRAME_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_addr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_addr),
    .rd_data (ram_rdata)
  );

  // Absolute difference, running sum, threshold compare and output register
  fdmd_accum u_accum (
    .clk                 (clk),
    .rst_n               (rst_n),
    .s1_valid            (s1_valid),
    .s1_word             (s1_word),
    .old_byte            (ram_rdata),
    .stall               (stall),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_motion_detected (out_motion_detected),
    .out_difference_sum  (out_difference_sum)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
  import fdmd_pkg::*;
();

  localparam int LIMIT_CYCLES   = 1_000_000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_WORDS   = 650;
  localparam int REPORT_LIMIT   = 10;
  localparam int FILL_LEN       = 128;   // longest frame used; the first frame writes it all

  // Content of the bytes that make up a frame
  typedef enum {FILL_CONST, FILL_RANDOM, FILL_NEAR} frame_fill_t;

  typedef struct packed {
    logic             motion;
    logic [SUM_W-1:0] sum;
  } motion_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  in_pixel_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_motion_detected;
  logic [SUM_W-1:0]  out_difference_sum;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  frame_difference_motion_detector u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pixel_byte       (in_pixel_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_motion_detected (out_motion_detected),
    .out_difference_sum  (out_difference_sum),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #6 clk = ~clk;

  // Detector mirror: stored frame, position, frame parity and running sum
  logic [PIX_W-1:0]  prev_frame_mem [MAX_FRAME_BYTES];
  int unsigned       pix_pos = 0;
  bit                skip_frame = 1'b0;
  bit                have_prev = 1'b0;
  int unsigned       diff_acc = 0;
  logic [LEN_W-1:0]  cfg_len = FRAME_BYTES_RST;
  logic [SENS_W-1:0] cfg_sens = SENSITIVITY_RST;

  motion_result_t    expected_q [$];

  int                mismatches = 0;
  int                results_seen = 0;
  int                words_sent = 0;
  int                cycle_count = 0;
  int                hold_left = 0;     // receiver hold-off, counted down by the receiver
  int                tx_idle_pct = 26;
  int                rx_idle_pct = 26;

  // ---------------------------------------------------------------------------
  // Mirror of the detector
  // ---------------------------------------------------------------------------

  // Zero length behaves as one byte; anything past the store depth saturates.
  function automatic int unsigned eff_len();
    int unsigned len;
    len = cfg_len;
    if (len == 0) len = 1;
    if (len > MAX_FRAME_BYTES) len = MAX_FRAME_BYTES;
    return len;
  endfunction

  // Position the next byte lands on; a shrunk length pins it to the last byte.
  function automatic int unsigned cur_pos();
    int unsigned len;
    len = eff_len();
    return (pix_pos >= len) ? len - 1 : pix_pos;
  endfunction

  // Pick a byte at distance d from the stored one (d up to 128 always fits).
  function automatic logic [PIX_W-1:0] near_byte(input int unsigned pos, input int unsigned d);
    int unsigned old;
    old = prev_frame_mem[pos];
    return (old + d <= 255) ? PIX_W'(old + d) : PIX_W'(old - d);
  endfunction

  // Advance the mirror by one accepted byte; queue the result it causes, if any.
  task automatic advance_detector(input logic [PIX_W-1:0] px);
    int unsigned     len, pos, old, d, s;
    longint unsigned lhs, rhs;
    bit              last;
    motion_result_t  r;
    len  = eff_len();
    pos  = cur_pos();
    last = (pos + 1 >= len);
    if (!skip_frame) begin
      if (have_prev) begin
        old      = prev_frame_mem[pos];
        d        = (px >= old) ? px - old : old - px;
        s        = diff_acc + d;
        diff_acc = (s > SUM_MAX) ? SUM_MAX : s;
      end
      prev_frame_mem[pos] = px;
    end
    if (last) begin
      if (!skip_frame) begin
        if (have_prev) begin
          // Exact form of "mean difference above threshold"
          lhs      = longint'(diff_acc) * 16;
          rhs      = longint'(cfg_sens) * len;
          r.motion = (lhs > rhs);
          r.sum    = diff_acc[SUM_W-1:0];
          expected_q.push_back(r);
        end
        have_prev = 1'b1;
      end
      diff_acc   = 0;
      pix_pos    = 0;
      skip_frame = !skip_frame;
    end else begin
      pix_pos = pos + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check every taken word, idle at random or hold off on request
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t ns: %s", $realtime, msg);
  endtask

  task automatic check_result();
    motion_result_t exp_r;
    results_seen++;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result: motion %0b sum %0d",
                                out_motion_detected, out_difference_sum));
    end else begin
      exp_r = expected_q.pop_front();
      if (out_motion_detected !== exp_r.motion)
        report_mismatch($sformatf("motion_detected: expected %0b, got %0b",
                                  exp_r.motion, out_motion_detected));
      if (out_difference_sum !== exp_r.sum)
        report_mismatch($sformatf("difference_sum: expected %0d, got %0d",
                                  exp_r.sum, out_difference_sum));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
    // Hold off for the requested stretch, else stall at random
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one byte, idling first at random; hold it until the block takes it.
  task automatic push_pixel(input logic [PIX_W-1:0] px);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel_byte <= px;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    advance_detector(px);
  endtask

  // Send bytes until the current frame closes or the limit is reached.
  task automatic send_pixels(input frame_fill_t mode, input int unsigned fill,
                             input int unsigned limit);
    int unsigned      n;
    logic [PIX_W-1:0] px;
    n = 0;
    do begin
      case (mode)
        FILL_CONST:  px = fill[PIX_W-1:0];
        FILL_RANDOM: px = PIX_W'($urandom_range(0, 255));
        default:     px = near_byte(cur_pos(), $urandom_range(0, 1 << $urandom_range(0, 7)));
      endcase
      push_pixel(px);
      n++;
    end while (pix_pos != 0 && n < limit);
  endtask

  // Skip past an odd frame first so the frame sent is a compared one.
  task automatic send_compared_frame(input frame_fill_t mode, input int unsigned fill);
    if (skip_frame) send_pixels(FILL_RANDOM, 0, MAX_FRAME_BYTES);
    send_pixels(mode, fill, MAX_FRAME_BYTES);
  endtask

  // Drop valid, drain every expected result, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] reg_addr(input logic [REG_IDX_W-1:0] idx);
    return ADDR_W'({idx, 2'b00});
  endfunction

  // Setup and access cycle; junk above the field width must be ignored.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    logic [DATA_W-1:0] word;
    word = $urandom;
    if (idx == REG_FRAME_BYTES) word[LEN_W-1:0] = value[LEN_W-1:0];
    else word[SENS_W-1:0] = value[SENS_W-1:0];
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(idx);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FRAME_BYTES) cfg_len = word[LEN_W-1:0];
    else cfg_sens = word[SENS_W-1:0];
  endtask

  task automatic read_reg(input logic [REG_IDX_W-1:0] idx, output logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(idx);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Read back both registers straight out of reset.
  task automatic test_reset_values();
    logic [DATA_W-1:0] data;
    read_reg(REG_FRAME_BYTES, data);
    if (data[LEN_W-1:0] !== FRAME_BYTES_RST)
      report_mismatch($sformatf("frame_bytes after reset: expected %0d, got %0d",
                                FRAME_BYTES_RST, data[LEN_W-1:0]));
    read_reg(REG_SENSITIVITY, data);
    if (data[SENS_W-1:0] !== SENSITIVITY_RST)
      report_mismatch($sformatf("sensitivity_q4 after reset: expected %0d, got %0d",
                                SENSITIVITY_RST, data[SENS_W-1:0]));
  endtask

  // Fill every entry later frames use with zeros as the first processed frame,
  // skip a short frame, then compare all 0xFF at the same length: the largest
  // sum with the top threshold lands exactly on the boundary. Then open a frame
  // at an oversized (saturated) length and close it early with a shorter one.
  // Run at full input rate: this is the long stretch with no sender idling.
  task automatic test_full_length_frames();
    tx_idle_pct = 0;
    write_reg(REG_SENSITIVITY, 4080);
    write_reg(REG_FRAME_BYTES, FILL_LEN);
    send_pixels(FILL_CONST, 0, MAX_FRAME_BYTES);
    settle();
    write_reg(REG_FRAME_BYTES, 3);
    send_pixels(FILL_RANDOM, 0, MAX_FRAME_BYTES);
    settle();
    write_reg(REG_FRAME_BYTES, FILL_LEN);
    send_pixels(FILL_CONST, 255, MAX_FRAME_BYTES);
    settle();
    write_reg(REG_FRAME_BYTES, 32'h3FFFF);
    send_pixels(FILL_RANDOM, 0, 5);
    settle();
    write_reg(REG_FRAME_BYTES, 3);
    send_pixels(FILL_RANDOM, 0, 1);
    settle();
    tx_idle_pct = 26;
  endtask

  // Zero length acts as one byte: each byte is a frame, every other one compared.
  task automatic test_unit_frames();
    logic [PIX_W-1:0] seq [8];
    seq = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'hFE};
    write_reg(REG_FRAME_BYTES, 0);
    write_reg(REG_SENSITIVITY, 0);
    foreach (seq[i]) send_pixels(FILL_CONST, seq[i], 1);
    settle();
    write_reg(REG_FRAME_BYTES, 1);
    send_pixels(FILL_CONST, 8'h80, 1);
    send_pixels(FILL_CONST, 8'h7F, 1);
    settle();
  endtask

  // Sums sitting exactly on the threshold and one step past it.
  task automatic test_threshold_edges();
    write_reg(REG_FRAME_BYTES, 4);
    write_reg(REG_SENSITIVITY, 16);
    send_compared_frame(FILL_CONST, 10);
    send_compared_frame(FILL_CONST, 11);    // sum 4, mean exactly 1.0
    settle();
    write_reg(REG_SENSITIVITY, 15);
    send_compared_frame(FILL_CONST, 10);    // sum 4, just above 0.9375
    settle();
    write_reg(REG_FRAME_BYTES, 1);
    write_reg(REG_SENSITIVITY, 4080);
    send_compared_frame(FILL_CONST, 0);
    send_compared_frame(FILL_CONST, 255);   // full swing equals the top threshold
    settle();
    write_reg(REG_SENSITIVITY, 4079);
    send_compared_frame(FILL_CONST, 0);
    settle();
  endtask

  // Shrink the length below the current position, then grow it mid-frame.
  task automatic test_mid_frame_length();
    write_reg(REG_FRAME_BYTES, 10);
    write_reg(REG_SENSITIVITY, 32);
    if (skip_frame) send_pixels(FILL_RANDOM, 0, MAX_FRAME_BYTES);
    send_pixels(FILL_RANDOM, 0, 6);
    settle();
    write_reg(REG_FRAME_BYTES, 3);
    send_pixels(FILL_RANDOM, 0, 1);         // pinned to the last byte, closes the frame
    settle();
    write_reg(REG_FRAME_BYTES, 4);
    if (skip_frame) send_pixels(FILL_RANDOM, 0, MAX_FRAME_BYTES);
    send_pixels(FILL_NEAR, 0, 2);
    settle();
    write_reg(REG_FRAME_BYTES, 9);
    send_pixels(FILL_NEAR, 0, MAX_FRAME_BYTES);
    settle();
  endtask

  // Hold the receiver off while one-byte frames keep coming: the block must
  // fill and stall its input. The closing drain is the sender pause.
  task automatic test_backpressure();
    write_reg(REG_FRAME_BYTES, 1);
    write_reg(REG_SENSITIVITY, $urandom_range(0, 4080));
    hold_left   = 400;
    tx_idle_pct = 0;
    repeat (120) send_pixels(FILL_RANDOM, 0, 1);
    tx_idle_pct = 26;
    settle();
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return 1;
    if (r < 80) return $urandom_range(2, 24);
    if (r < 98) return $urandom_range(25, 100);
    return $urandom_range(101, FILL_LEN);
  endfunction

  function automatic int unsigned pick_sensitivity();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 160);   // near the mean of small changes
    if (r < 80) return $urandom_range(0, 4080);
    return (r < 90) ? 0 : 4080;
  endfunction

  // Mostly whole frames of random content, with settings changed between
  // frames and now and then in the middle of one.
  task automatic test_random_traffic();
    int          start_words, r, remaining;
    frame_fill_t mode;
    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      // Run a stretch with no idling on either side
      if (words_sent - start_words >= 200 && words_sent - start_words < 450) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 26;
        rx_idle_pct = 26;
      end
      r = $urandom_range(0, 99);
      mode = (r < 55) ? FILL_NEAR : (r < 85) ? FILL_RANDOM : FILL_CONST;
      r = $urandom_range(0, 99);
      if (r < 72) begin
        send_pixels(mode, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                          : ($urandom_range(0, 1) ? 255 : 0), MAX_FRAME_BYTES);
      end else if (r < 88) begin
        settle();
        r = $urandom_range(0, 99);
        if (r < 75) write_reg(REG_FRAME_BYTES, pick_length());
        if (r >= 50) write_reg(REG_SENSITIVITY, pick_sensitivity());
      end else begin
        // Stop part way into a frame and change its length
        remaining = eff_len() - cur_pos();
        if (remaining > 1) send_pixels(mode, 0, $urandom_range(1, remaining - 1));
        settle();
        write_reg(REG_FRAME_BYTES, pick_length());
      end
    end
    tx_idle_pct = 26;
    rx_idle_pct = 26;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_full_length_frames();
    test_unit_frames();
    test_threshold_edges();
    test_mid_frame_length();
    test_backpressure();
    test_random_traffic();
    settle();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* frame_difference_motion_detector.f */
src/fdmd_pkg.sv
src/fdmd_ram.sv
src/fdmd_front.sv
src/fdmd_accum.sv
src/frame_difference_motion_detector.sv
bench/tb_top.sv
